// File: sv/sblc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_pkg
// Shared widths, constants and types of the slope band line compressor.
// ----------------------------------------------------------------------------
package sblc_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned BAND_W     = 31;
  localparam int unsigned SLOPE_W    = 64;
  // signed numerator dy +/- band and its magnitude
  localparam int unsigned NUM_W      = 34;
  localparam int unsigned MAG_W      = 33;
  // dividend is the magnitude with the fraction bits appended
  localparam int unsigned DIVD_W     = MAG_W + FRAC_BITS;
  localparam int unsigned DCNT_W     = $clog2(DIVD_W + 1);
  // time gap factor of the vertex offset
  localparam int unsigned GAP_W      = TIME_W + 1;
  localparam int unsigned MCNT_W     = $clog2(TIME_W + 1);
  // vertex offset is capped at 2^CAP_EXP
  localparam int unsigned CAP_EXP    = 40;
  localparam int unsigned OFS_W      = CAP_EXP + 1;
  localparam int unsigned ACC_W      = CAP_EXP + FRAC_BITS;
  localparam int unsigned VSUM_W     = OFS_W + 2;

  localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(655360);
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PREP = 9'b000000010,
    ST_DIV  = 9'b000000100,
    ST_CMP  = 9'b000001000,
    ST_SUM  = 9'b000010000,
    ST_MID  = 9'b000100000,
    ST_MST  = 9'b001000000,
    ST_MUL  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_e;

  typedef struct packed {
    logic                      done;
    logic signed [SLOPE_W-1:0] slope;
  } div_rsp_t;

  typedef struct packed {
    logic             done;
    logic             neg;
    logic [OFS_W-1:0] mag;
  } mul_rsp_t;

endpackage

// File: sv/sblc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_div
// Bit-serial restoring divider: signed numerator shifted by the fraction
// bits over an unsigned time gap, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sblc_div
  import sblc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [TIME_W-1:0]       dt_i,
  output div_rsp_t                rsp_o
);

  logic                busy_q, busy_d;
  logic                fin_q, fin_d;
  logic                done_q, done_d;
  logic [DCNT_W-1:0]   cnt_q, cnt_d;
  logic [DIVD_W-1:0]   dvd_q, dvd_d;
  logic [DIVD_W-1:0]   quo_q, quo_d;
  logic [TIME_W-1:0]   rem_q, rem_d;
  logic [TIME_W-1:0]   dt_q, dt_d;
  logic                neg_q, neg_d;
  logic [SLOPE_W-1:0]  slope_q, slope_d;
  logic [NUM_W-1:0]    num_abs;
  logic [TIME_W:0]     trial;
  logic                ge;
  logic [SLOPE_W-1:0]  quo_ext;

  // magnitude of the numerator and one trial subtraction
  always_comb begin
    num_abs = num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
    trial   = {rem_q, dvd_q[DIVD_W-1]};
    ge      = trial >= {1'b0, dt_q};
    quo_ext = SLOPE_W'(quo_q);
  end

  always_comb begin
    busy_d  = busy_q;
    fin_d   = 1'b0;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dt_d    = dt_q;
    neg_d   = neg_q;
    slope_d = slope_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(DIVD_W);
      dvd_d  = {num_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
      quo_d  = '0;
      rem_d  = '0;
      dt_d   = dt_i;
      neg_d  = num_i[NUM_W-1];
    end else if (busy_q) begin
      rem_d = ge ? TIME_W'(trial - {1'b0, dt_q}) : trial[TIME_W-1:0];
      quo_d = {quo_q[DIVD_W-2:0], ge};
      dvd_d = {dvd_q[DIVD_W-2:0], 1'b0};
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    // apply the sign once all quotient bits are in
    if (fin_q) begin
      slope_d = neg_q ? (~quo_ext + SLOPE_W'(1)) : quo_ext;
      done_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    dt_q    <= dt_d;
    neg_q   <= neg_d;
    slope_q <= slope_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.slope = slope_q;

endmodule

// File: sv/sblc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblc_mul
// Bit-serial saturating multiplier: mid slope times time gap, scaled down
// by the fraction bits and capped, one gap bit per cycle.
// ----------------------------------------------------------------------------
module sblc_mul
  import sblc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [SLOPE_W-1:0] mid_i,
  input  logic signed [GAP_W-1:0]   gap_i,
  output mul_rsp_t                  rsp_o
);

  localparam int unsigned SUM_W = SLOPE_W + 1;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [MCNT_W-1:0]   cnt_q, cnt_d;
  logic [SLOPE_W-1:0]  mm_q, mm_d;
  logic [TIME_W-1:0]   gm_q, gm_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic                sat_q, sat_d;
  logic                neg_q, neg_d;
  logic [SLOPE_W-1:0]  mid_abs;
  logic [GAP_W-1:0]    gap_abs;
  logic [SUM_W-1:0]    sum;

  // operand magnitudes and one shift-add step
  always_comb begin
    mid_abs = mid_i[SLOPE_W-1] ? (~mid_i + SLOPE_W'(1)) : mid_i;
    gap_abs = gap_i[GAP_W-1] ? (~gap_i + GAP_W'(1)) : gap_i;
    sum     = SUM_W'({acc_q, 1'b0}) + (gm_q[TIME_W-1] ? SUM_W'(mm_q) : '0);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mm_d   = mm_q;
    gm_d   = gm_q;
    acc_d  = acc_q;
    sat_d  = sat_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = MCNT_W'(TIME_W);
      mm_d   = mid_abs;
      gm_d   = gap_abs[TIME_W-1:0];
      acc_d  = '0;
      sat_d  = 1'b0;
      neg_d  = mid_i[SLOPE_W-1] ^ gap_i[GAP_W-1];
    end else if (busy_q) begin
      acc_d = sum[ACC_W-1:0];
      if (sum[SUM_W-1:ACC_W] != '0) begin
        sat_d = 1'b1;
      end
      gm_d  = {gm_q[TIME_W-2:0], 1'b0};
      cnt_d = cnt_q - MCNT_W'(1);
      if (cnt_q == MCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mm_q  <= mm_d;
    gm_q  <= gm_d;
    acc_q <= acc_d;
    sat_q <= sat_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.neg  = neg_q;
  assign rsp_o.mag  = sat_q ? (OFS_W'(1) << CAP_EXP) : OFS_W'(acc_q[ACC_W-1:FRAC_BITS]);

endmodule

// File: sv/slope_band_line_compressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_band_line_compressor
// Swinging-door style compressor of timestamped samples into line vertices.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries samples: tdata = sample_time, sample_value; tuser = mode
//   (0 sample, 1 flush). m_axis carries vertices: tdata = vertex_time,
//   vertex_value; tuser = is_closing. cfg_* writes the deviation band at
//   any time the block is idle; it is always ready.
//   One item is worked on at a time; s_axis_tready is high only when the
//   control sequencer waits for a new item.
//   A narrowing sample waits on the two serial dividers (49 quotient
//   bits) working side by side. A sample that ends a segment then adds the
//   mid slope and the 32-step serial multiplier; a flush runs the mid slope
//   and the multiplier without the dividers; the first sample and a
//   sample not later than the anchor skip both serial units.
//   The vertex sits in an output register, so the next item is taken while
//   it waits; if the receiver stalls and a further vertex is ready, the
//   sequencer holds until the register is free.
//   Reset clears the anchor and latest point, opens the slope interval,
//   loads the default band (10.0) and drops any pending vertex.
// ----------------------------------------------------------------------------
module slope_band_line_compressor
  import sblc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [BAND_W-1:0]    cfg_data_i,     // deviation_band
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // sample_time, sample_value
  input  logic [0:0]           s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // vertex_time, vertex_value
  output logic [0:0]           m_axis_tuser    // is_closing
);

  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};

  state_e                     state_q, state_d;
  logic [BAND_W-1:0]          band_q, band_d;
  logic                       started_q, started_d;
  logic [TIME_W-1:0]          anchor_t_q, anchor_t_d;
  logic signed [VAL_W-1:0]    anchor_v_q, anchor_v_d;
  logic [TIME_W-1:0]          latest_t_q, latest_t_d;
  logic signed [SLOPE_W-1:0]  floor_q, floor_d;
  logic signed [SLOPE_W-1:0]  ceil_q, ceil_d;
  logic [TIME_W-1:0]          samp_t_q, samp_t_d;
  logic [TIME_W-1:0]          dt_q, dt_d;
  logic signed [MAG_W-1:0]    dy_q, dy_d;
  logic                       closing_q, closing_d;
  logic                       pend_q, pend_d;
  logic signed [SLOPE_W:0]    sum_q, sum_d;
  logic signed [SLOPE_W-1:0]  mid_q, mid_d;
  logic [TIME_W-1:0]          res_t_q, res_t_d;
  logic signed [VAL_W-1:0]    res_v_q, res_v_d;
  logic                       res_c_q, res_c_d;
  logic                       m_valid_q, m_valid_d;
  logic [63:0]                m_data_q, m_data_d;
  logic                       m_user_q, m_user_d;

  logic                       in_xfer;
  logic                       out_free;
  logic [TIME_W-1:0]          in_t;
  logic signed [VAL_W-1:0]    in_v;
  logic signed [NUM_W-1:0]    num_lo, num_hi;
  logic                       div_start, mul_start;
  div_rsp_t                   lo_rsp, hi_rsp;
  mul_rsp_t                   mul_rsp;
  logic signed [GAP_W-1:0]    gap;
  logic signed [SLOPE_W:0]    sum_p1;
  logic signed [VSUM_W-1:0]   vsum;
  logic signed [VAL_W-1:0]    vsat;
  logic                       disjoint;

  assign in_t          = s_axis_tdata[TIME_W-1:0];
  assign in_v          = s_axis_tdata[TIME_W+VAL_W-1:TIME_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // slope band numerators and the vertex offset datapath
  always_comb begin
    num_lo   = NUM_W'(dy_q) - NUM_W'($signed({1'b0, band_q}));
    num_hi   = NUM_W'(dy_q) + NUM_W'($signed({1'b0, band_q}));
    gap      = $signed({1'b0, latest_t_q}) - $signed({1'b0, anchor_t_q});
    sum_p1   = sum_q + (SLOPE_W+1)'(1);
    disjoint = (lo_rsp.slope > ceil_q) || (hi_rsp.slope < floor_q);
    vsum     = mul_rsp.neg ? (VSUM_W'(anchor_v_q) - $signed(VSUM_W'(mul_rsp.mag)))
                           : (VSUM_W'(anchor_v_q) + $signed(VSUM_W'(mul_rsp.mag)));
    if (vsum[VSUM_W-1:VAL_W-1] == '0 || vsum[VSUM_W-1:VAL_W-1] == '1) begin
      vsat = vsum[VAL_W-1:0];
    end else if (vsum[VSUM_W-1]) begin
      vsat = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      vsat = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // control sequencer and line state
  always_comb begin
    state_d    = state_q;
    band_d     = band_q;
    started_d  = started_q;
    anchor_t_d = anchor_t_q;
    anchor_v_d = anchor_v_q;
    latest_t_d = latest_t_q;
    floor_d    = floor_q;
    ceil_d     = ceil_q;
    samp_t_d   = samp_t_q;
    dt_d       = dt_q;
    dy_d       = dy_q;
    closing_d  = closing_q;
    pend_d     = pend_q;
    sum_d      = sum_q;
    mid_d      = mid_q;
    res_t_d    = res_t_q;
    res_v_d    = res_v_q;
    res_c_d    = res_c_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_user_d   = m_user_q;
    div_start  = 1'b0;
    mul_start  = 1'b0;

    if (cfg_valid_i) begin
      band_d = cfg_data_i;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          priority if (s_axis_tuser[0] == MODE_FLUSH) begin
            if (started_q) begin
              closing_d = 1'b1;
              pend_d    = 1'b0;
              state_d   = ST_SUM;
            end
          end else if (!started_q) begin
            started_d  = 1'b1;
            anchor_t_d = in_t;
            anchor_v_d = in_v;
            latest_t_d = in_t;
            floor_d    = SLOPE_MIN;
            ceil_d     = SLOPE_MAX;
            res_t_d    = in_t;
            res_v_d    = in_v;
            res_c_d    = 1'b0;
            state_d    = ST_EMIT;
          end else if (in_t <= anchor_t_q) begin
            latest_t_d = in_t;
          end else begin
            samp_t_d = in_t;
            dt_d     = in_t - anchor_t_q;
            dy_d     = MAG_W'(in_v) - MAG_W'(anchor_v_q);
            state_d  = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (lo_rsp.done) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (disjoint) begin
          closing_d = 1'b0;
          pend_d    = 1'b1;
          state_d   = ST_SUM;
        end else begin
          latest_t_d = samp_t_q;
          if (lo_rsp.slope > floor_q) begin
            floor_d = lo_rsp.slope;
          end
          if (hi_rsp.slope < ceil_q) begin
            ceil_d = hi_rsp.slope;
          end
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        sum_d   = (SLOPE_W+1)'(floor_q) + (SLOPE_W+1)'(ceil_q);
        state_d = ST_MID;
      end
      ST_MID: begin
        // halve, truncating toward zero
        mid_d   = sum_q[SLOPE_W] ? sum_p1[SLOPE_W:1] : sum_q[SLOPE_W:1];
        state_d = ST_MST;
      end
      ST_MST: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          res_t_d    = latest_t_q;
          res_v_d    = vsat;
          res_c_d    = closing_q;
          anchor_t_d = latest_t_q;
          anchor_v_d = vsat;
          floor_d    = SLOPE_MIN;
          ceil_d     = SLOPE_MAX;
          if (pend_q) begin
            latest_t_d = samp_t_q;
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_v_q, res_t_q};
          m_user_d  = res_c_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      band_q     <= BAND_RESET;
      started_q  <= 1'b0;
      anchor_t_q <= '0;
      anchor_v_q <= '0;
      latest_t_q <= '0;
      floor_q    <= SLOPE_MIN;
      ceil_q     <= SLOPE_MAX;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      band_q     <= band_d;
      started_q  <= started_d;
      anchor_t_q <= anchor_t_d;
      anchor_v_q <= anchor_v_d;
      latest_t_q <= latest_t_d;
      floor_q    <= floor_d;
      ceil_q     <= ceil_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_t_q  <= samp_t_d;
    dt_q      <= dt_d;
    dy_q      <= dy_d;
    closing_q <= closing_d;
    pend_q    <= pend_d;
    sum_q     <= sum_d;
    mid_q     <= mid_d;
    res_t_q   <= res_t_d;
    res_v_q   <= res_v_d;
    res_c_q   <= res_c_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  // lower and upper band slopes, side by side
  sblc_div u_div_lo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_lo),
    .dt_i    (dt_q),
    .rsp_o   (lo_rsp)
  );

  sblc_div u_div_hi (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_hi),
    .dt_i    (dt_q),
    .rsp_o   (hi_rsp)
  );

  // vertex offset along the mid slope
  sblc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mid_i   (mid_q),
    .gap_i   (gap),
    .rsp_o   (mul_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_rsp.done |-> (state_q == ST_DIV && hi_rsp.done))
    else $error("divider result outside the wait state");

  a_mul_in_mul_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> state_q == ST_MUL)
    else $error("multiplier result outside the wait state");

  a_no_vertex_before_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !started_q |-> !m_valid_q)
    else $error("vertex offered before the first sample");

  a_interval_ordered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    floor_q <= ceil_q)
    else $error("slope interval inverted");
`endif

endmodule

// File: dv/slope_band_line_compressor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_band_line_compressor_tb
// Drives samples and flushes into the compressor, predicts every vertex in
// a local model of the slope interval and compares the vertex stream.
// ----------------------------------------------------------------------------
module slope_band_line_compressor_tb;
  import sblc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [31:0] vtime;
    logic [31:0] vvalue;
    logic        closing;
  } vertex_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [BAND_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;

  // predictor state
  logic [30:0] band_q;
  logic [31:0] anc_t, lat_t;
  longint      anc_v;
  longint      slope_lo, slope_hi;
  bit          started_q;

  vertex_t     vertex_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;   // stretch with no idling
  logic [31:0] tnow;

  slope_band_line_compressor dut (.*);

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // slope (num << 16) / dt truncated toward zero
  function automatic longint band_slope(longint num, logic [31:0] dt);
    logic [63:0] mag;
    mag = (num < 0) ? -num : num;
    mag = (mag << FRAC_BITS) / {32'd0, dt};
    return (num < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint vertex_value_at_latest();
    logic signed [65:0] mid;
    logic signed [65:0] gap;
    logic [65:0]        mm, gm;
    logic [127:0]       prod;
    logic [127:0]       mag;
    longint             res;
    mid = ($signed({{2{slope_lo[63]}}, slope_lo}) + $signed({{2{slope_hi[63]}}, slope_hi}))
          / 2;
    gap = $signed({34'd0, lat_t}) - $signed({34'd0, anc_t});
    mm = (mid < 0) ? -mid : mid;
    gm = (gap < 0) ? -gap : gap;
    prod = {62'd0, mm} * {62'd0, gm};
    mag = prod >> FRAC_BITS;
    if (mag > (128'd1 << CAP_EXP)) mag = 128'd1 << CAP_EXP;
    res = ((mid < 0) != (gap < 0)) ? anc_v - longint'(mag[63:0])
                                   : anc_v + longint'(mag[63:0]);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res;
  endfunction

  task automatic emit_vertex(bit closing);
    vertex_t vx;
    longint  v;
    v = vertex_value_at_latest();
    vx.vtime = lat_t;
    vx.vvalue = v[31:0];
    vx.closing = closing;
    vertex_q.push_back(vx);
    anc_t = lat_t;
    anc_v = v;
    slope_lo = 64'h8000_0000_0000_0000;
    slope_hi = 64'h7fff_ffff_ffff_ffff;
  endtask

  task automatic predict(bit mode, logic [31:0] t, logic [31:0] val);
    longint dy, lo, hi;
    if (mode == MODE_FLUSH) begin
      if (started_q) emit_vertex(1'b1);
    end else if (!started_q) begin
      started_q = 1'b1;
      anc_t = t;
      anc_v = longint'($signed(val));
      lat_t = t;
      vertex_q.push_back({t, val, 1'b0});
    end else if (t <= anc_t) begin
      lat_t = t;
    end else begin
      dy = longint'($signed(val)) - anc_v;
      lo = band_slope(dy - longint'(band_q), t - anc_t);
      hi = band_slope(dy + longint'(band_q), t - anc_t);
      if (lo > slope_hi || hi < slope_lo) begin
        emit_vertex(1'b0);
        lat_t = t;
      end else begin
        lat_t = t;
        if (lo > slope_lo) slope_lo = lo;
        if (hi < slope_hi) slope_hi = hi;
      end
    end
  endtask

  // send one item, predicting on transfer
  task automatic send_item(bit mode, logic [31:0] t, logic [31:0] val);
    while (!calm && $urandom_range(99) < 10) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = {val, t};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict(mode, t, val);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (vertex_q.size() != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_band(logic [30:0] b);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= b;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    band_q = b;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stalls
  always @(negedge clk_i)
    m_axis_tready <= calm || ($urandom_range(99) >= 10);

  // vertex checker
  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser[0]};
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex %h", got);
      end else begin
        want = vertex_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: expected t=%h v=%h c=%b, got t=%h v=%h c=%b",
                     want.vtime, want.vvalue, want.closing,
                     got.vtime, got.vvalue, got.closing);
        end
      end
    end
  end

  // directed extremes and special cases
  task automatic test_directed();
    send_item(1'b1, 32'd5, 32'd0);               // flush before first sample
    send_item(1'b0, 32'd100, 32'h0001_0000);     // first sample
    send_item(1'b0, 32'd50, 32'h7fff_ffff);      // time before anchor
    send_item(1'b1, 32'd0, 32'd0);               // closing with negative gap
    send_item(1'b0, 32'd200, 32'h0002_0000);
    send_item(1'b0, 32'd300, 32'h0003_0000);
    send_item(1'b0, 32'd301, 32'h8000_0000);     // disjoint band
    send_item(1'b0, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(1'b1, 32'hffff_ffff, 32'hffff_ffff);
    send_item(1'b0, 32'hffff_fff0, 32'h8000_0000);
    send_item(1'b0, 32'hffff_ffff, 32'h7fff_ffff);
    send_item(1'b1, 32'd0, 32'd0);
  endtask

  task automatic test_band_extremes();
    write_band(31'd0);
    tnow = 32'd1000;
    for (int i = 0; i < 12; i++) begin
      tnow += 1 + $urandom_range(3);
      send_item(1'b0, tnow, $urandom);
    end
    write_band(31'h7fff_ffff);
    for (int i = 0; i < 12; i++) begin
      tnow += 1 + $urandom_range(1000);
      send_item(1'b0, tnow, $urandom);
    end
    send_item(1'b1, 32'd0, 32'd0);
  endtask

  // random segments of near-linear samples with noise
  task automatic test_random(int unsigned n);
    int     v, slope_step;
    bit     md;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        write_band(31'($urandom_range(3) == 0 ? $urandom : $urandom_range(2_000_000)));
        tnow = $urandom_range(3) == 0 ? $urandom : $urandom_range(1000);
        v = $urandom;
        slope_step = $signed($urandom_range(200_000)) - 100_000;
      end
      calm = (i % 500) >= 400;
      if (i == n / 2) drain();   // sender holds until everything arrives
      md = ($urandom_range(99) < 4);
      case ($urandom_range(9))
        0: send_item(md, $urandom, $urandom);   // noise, times may go back
        default: begin
          tnow += 1 + $urandom_range(($urandom_range(9) == 0) ? 100_000 : 20);
          v += slope_step + $signed($urandom_range(1_600_000)) - 800_000;
          send_item(md, tnow, v);
        end
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    band_q = BAND_RESET;
    anc_t = '0; lat_t = '0; anc_v = 0; started_q = 1'b0;
    slope_lo = 64'h8000_0000_0000_0000;
    slope_hi = 64'h7fff_ffff_ffff_ffff;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_band_extremes();
    test_random(1600);
    drain();
    if (mismatches == 0 && vertex_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
